// ===== hw/rtl/huffman_lookup_table_builder_top_macros.svh =====
// assertion macros for the huffman lookup table builder
`ifndef HUFFMAN_LOOKUP_TABLE_BUILDER_TOP_MACROS_SVH
`define HUFFMAN_LOOKUP_TABLE_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HLTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HLTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLTB_ASSERT(lbl, prop, msg)
`define HLTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/hltb_pkg.sv =====
// types, codes and helpers shared by the huffman lookup table builder
`default_nettype none
package hltb_pkg;

  localparam int SLOTS_PER_CLASS = 4;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int TABLE_AW        = 16;
  localparam int SLOT_W          = 3;
  localparam int MEM_AW          = SLOT_W + TABLE_AW;
  localparam int ENTRY_W         = 13;
  localparam int FILL_W          = TABLE_AW + 1;
  localparam int COST_W          = 23;
  localparam int IDX_W           = 5;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_COUNT  = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd1;
  localparam logic [2:0] ST_OVER      = 3'd2;
  localparam logic [2:0] ST_SEQ       = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COUNTS  = 2'd1;
  localparam logic [1:0] PH_SYMBOLS = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        table_class;
    logic [3:0]  table_slot;
    logic [7:0]  data_byte;
    logic [15:0] code_window;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] code_length;
    logic [7:0] symbol;
  } out_word_t;

  // lowest used length index at or above from, 16 when none
  function automatic logic [IDX_W-1:0] first_used(input logic [15:0] mask,
                                                  input logic [IDX_W-1:0] from);
    logic [IDX_W-1:0] res;
    res = IDX_W'(MAX_CODE_LENGTH);
    for (int i = MAX_CODE_LENGTH - 1; i >= 0; i--) begin
      if (mask[i] && (IDX_W'(i) >= from)) begin
        res = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hltb_ram.sv =====
// lookup entry memory, one write port and one registered read port
`default_nettype none
module hltb_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [hltb_pkg::MEM_AW-1:0]  wr_addr,
  input  logic [hltb_pkg::ENTRY_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [hltb_pkg::MEM_AW-1:0]  rd_addr,
  output logic [hltb_pkg::ENTRY_W-1:0] rd_data
);
  import hltb_pkg::*;

  logic [ENTRY_W-1:0] mem [(1 << MEM_AW)];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/huffman_lookup_table_builder_top.sv =====
// huffman lookup table builder: build sequencer, count bookkeeping and result register
//
//   channel | direction | handshake        | word
//   in      | input     | in_valid/stall   | hltb_pkg::in_word_t
//   out     | output    | out_valid/stall  | hltb_pkg::out_word_t
//
// start, count and bad or unbuilt lookups answer from S_IDLE; a lookup hit takes its memory read in S_LOOK
// symbol of length L: 2^(16-L) entry writes in S_FILL, one entry write per cycle on the memory port
// a word that ends a length or the count phase passes through S_ENTER to find the next used length,
// and S_CLEAR zero-fills the remaining 65536 - entries filled when it completes the table
// synchronous reset clears control state only; the memory is not cleared
// a result waiting on out_stall holds off the next input word
`default_nettype none
`include "huffman_lookup_table_builder_top_macros.svh"
module huffman_lookup_table_builder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hltb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hltb_pkg::out_word_t out_data
);
  import hltb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_ENTER = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [SLOT_W-1:0]    active_slot_r, active_slot_nxt;
  logic [7:0]           built_r, built_nxt;
  logic [7:0]           counts_r [MAX_CODE_LENGTH];
  logic [15:0]          nz_r, nz_nxt;
  logic [FILL_W-1:0]    budget_r, budget_nxt;
  logic [IDX_W-1:0]     len_idx_r, len_idx_nxt;
  logic [7:0]           sym_left_r, sym_left_nxt;
  logic [FILL_W-1:0]    fill_ptr_r, fill_ptr_nxt;
  logic [TABLE_AW-1:0]  fill_left_r, fill_left_nxt;
  logic [ENTRY_W-1:0]   fill_entry_r, fill_entry_nxt;
  logic [IDX_W-1:0]     enter_from_r, enter_from_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 accept;
  logic                 out_take;
  logic                 slot_ok;
  logic [4:0]           table_sum;
  logic [SLOT_W-1:0]    table_sel;
  logic [COST_W-1:0]    cost;
  logic [IDX_W-1:0]     next_len;
  logic                 cnt_we;
  logic                 cnt_clr;
  logic                 wr_en;
  logic [MEM_AW-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 rd_en;
  logic [MEM_AW-1:0]    rd_addr;
  logic [ENTRY_W-1:0]   rd_data;

  hltb_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign slot_ok   = in_data.table_slot < 4'(SLOTS_PER_CLASS);
  assign table_sum = (in_data.table_class ? 5'(SLOTS_PER_CLASS) : 5'd0)
                     + {1'b0, in_data.table_slot};
  assign table_sel = table_sum[SLOT_W-1:0];
  assign cost      = {in_data.data_byte, 15'd0} >> len_idx_r[3:0];
  assign next_len  = first_used(nz_r, enter_from_r);
  assign rd_addr   = {table_sel, in_data.code_window};
  assign wr_addr   = {active_slot_r, fill_ptr_r[TABLE_AW-1:0]};

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    active_slot_nxt = active_slot_r;
    built_nxt       = built_r;
    nz_nxt          = nz_r;
    budget_nxt      = budget_r;
    len_idx_nxt     = len_idx_r;
    sym_left_nxt    = sym_left_r;
    fill_ptr_nxt    = fill_ptr_r;
    fill_left_nxt   = fill_left_r;
    fill_entry_nxt  = fill_entry_r;
    enter_from_nxt  = enter_from_r;
    out_valid_nxt   = out_take ? 1'b0 : out_valid_r;
    out_word_nxt    = out_word_r;
    cnt_we          = 1'b0;
    cnt_clr         = 1'b0;
    wr_en           = 1'b0;
    wr_data         = fill_entry_r;
    rd_en           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_word_nxt = '0;
          unique case (in_data.kind)
            KIND_START: begin
              out_valid_nxt = 1'b1;
              if (!slot_ok) begin
                out_word_nxt.status = ST_BAD_SLOT;
              end else begin
                active_slot_nxt      = table_sel;
                built_nxt[table_sel] = 1'b0;
                cnt_clr              = 1'b1;
                nz_nxt               = '0;
                fill_ptr_nxt         = '0;
                budget_nxt           = FILL_W'(1 << TABLE_AW);
                len_idx_nxt          = '0;
                sym_left_nxt         = '0;
                phase_nxt            = PH_COUNTS;
              end
            end
            KIND_COUNT: begin
              out_valid_nxt = 1'b1;
              if (phase_r != PH_COUNTS || len_idx_r[IDX_W-1]) begin
                out_word_nxt.status = ST_SEQ;
              end else begin
                cnt_we                 = 1'b1;
                nz_nxt[len_idx_r[3:0]] = |in_data.data_byte;
                if (cost > COST_W'(budget_r)) begin
                  out_word_nxt.status = ST_OVER;
                  phase_nxt           = PH_IDLE;
                end else begin
                  budget_nxt  = budget_r - cost[FILL_W-1:0];
                  len_idx_nxt = len_idx_r + IDX_W'(1);
                  if (len_idx_r == IDX_W'(MAX_CODE_LENGTH - 1)) begin
                    phase_nxt      = PH_SYMBOLS;
                    enter_from_nxt = '0;
                    state_nxt      = S_ENTER;
                  end
                end
              end
            end
            KIND_SYMBOL: begin
              out_valid_nxt = 1'b1;
              if (phase_r != PH_SYMBOLS || len_idx_r[IDX_W-1] || sym_left_r == 8'd0) begin
                out_word_nxt.status = ST_SEQ;
              end else begin
                fill_left_nxt  = TABLE_AW'(1 << (TABLE_AW - 1)) >> len_idx_r[3:0];
                fill_entry_nxt = {len_idx_r + IDX_W'(1), in_data.data_byte};
                sym_left_nxt   = sym_left_r - 8'd1;
                state_nxt      = S_FILL;
              end
            end
            KIND_LOOKUP: begin
              if (!slot_ok) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = ST_BAD_SLOT;
              end else if (!built_r[table_sel]) begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = ST_NOT_BUILT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_LOOK;
              end
            end
          endcase
        end
      end
      S_LOOK: begin
        out_valid_nxt            = 1'b1;
        out_word_nxt.status      = ST_OK;
        out_word_nxt.code_length = rd_data[12:8];
        out_word_nxt.symbol      = rd_data[7:0];
        state_nxt                = S_IDLE;
      end
      S_FILL: begin
        if (fill_left_r != '0 && !fill_ptr_r[FILL_W-1]) begin
          wr_en         = 1'b1;
          fill_ptr_nxt  = fill_ptr_r + FILL_W'(1);
          fill_left_nxt = fill_left_r - TABLE_AW'(1);
        end else if (sym_left_r == 8'd0) begin
          enter_from_nxt = len_idx_r + IDX_W'(1);
          state_nxt      = S_ENTER;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ENTER: begin
        if (next_len[IDX_W-1]) begin
          len_idx_nxt  = IDX_W'(MAX_CODE_LENGTH);
          sym_left_nxt = '0;
          state_nxt    = S_CLEAR;
        end else begin
          len_idx_nxt  = next_len;
          sym_left_nxt = counts_r[next_len[3:0]];
          state_nxt    = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (!fill_ptr_r[FILL_W-1]) begin
          wr_en        = 1'b1;
          wr_data      = '0;
          fill_ptr_nxt = fill_ptr_r + FILL_W'(1);
        end else begin
          built_nxt[active_slot_r] = 1'b1;
          phase_nxt                = PH_IDLE;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_IDLE;
      active_slot_r <= '0;
      built_r       <= '0;
      nz_r          <= '0;
      budget_r      <= FILL_W'(1 << TABLE_AW);
      len_idx_r     <= '0;
      sym_left_r    <= '0;
      fill_ptr_r    <= '0;
      fill_left_r   <= '0;
      enter_from_r  <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      active_slot_r <= active_slot_nxt;
      built_r       <= built_nxt;
      nz_r          <= nz_nxt;
      budget_r      <= budget_nxt;
      len_idx_r     <= len_idx_nxt;
      sym_left_r    <= sym_left_nxt;
      fill_ptr_r    <= fill_ptr_nxt;
      fill_left_r   <= fill_left_nxt;
      enter_from_r  <= enter_from_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cnt_clr) begin
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
          counts_r[i] <= '0;
        end
      end else if (cnt_we) begin
        counts_r[len_idx_r[3:0]] <= in_data.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_entry_r <= fill_entry_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `HLTB_ASSERT(a_wr_in_table, wr_en |-> !fill_ptr_r[FILL_W-1], "write past end of table")
  `HLTB_ASSERT(a_look_result, (state_r == S_LOOK) |=> out_valid_r, "lookup result not loaded")
  `HLTB_ASSERT(a_clear_builds,
               (state_r == S_CLEAR && fill_ptr_r[FILL_W-1])
               |=> (built_r[active_slot_r] && phase_r == PH_IDLE),
               "finished table not marked built")

endmodule
`default_nettype wire
